FILE: design/mm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply block.
// ---------------------------------------------------------------------------
package mm_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int DIM_W       = 4;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 48;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_ISSUE,
    S_FLUSH,
    S_LOAD,
    S_DRAIN
  } state_t;

endpackage
`default_nettype wire

FILE: design/mm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mm_ram #(
  parameter int W = 16,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/mm_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mm_cell
// One column cell: holds a column of B, multiplies the passing A element,
// accumulates, and shifts finished sums toward the output.
// ---------------------------------------------------------------------------
module mm_cell #(
  parameter int MAX_DIM = mm_pkg::DEF_MAX_DIM,
  parameter int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            b_we,
  input  wire logic [DW-1:0]                   b_row,
  input  wire logic signed [mm_pkg::VAL_W-1:0] b_data,
  input  wire logic                            clr,
  input  wire logic                            in_v,
  input  wire logic [DW-1:0]                   in_k,
  input  wire logic signed [mm_pkg::VAL_W-1:0] in_a,
  output logic                                 out_v,
  output logic      [DW-1:0]                   out_k,
  output logic signed [mm_pkg::VAL_W-1:0]      out_a,
  input  wire logic                            ld,
  input  wire logic                            sh,
  input  wire logic signed [mm_pkg::SUM_W-1:0] res_in,
  output logic signed [mm_pkg::SUM_W-1:0]      res_out
);
  import mm_pkg::*;

  logic signed [VAL_W-1:0]  b_mem_r [MAX_DIM];
  logic                     v_r;
  logic [DW-1:0]            k_r;
  logic signed [VAL_W-1:0]  a_r;
  logic                     mul_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  res_r;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem_r[b_row] <= b_data;
    end
    k_r    <= in_k;
    a_r    <= in_a;
    prod_r <= in_a * b_mem_r[in_k];
    if (clr) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
    if (ld) begin
      res_r <= acc_r;
    end else if (sh) begin
      res_r <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      v_r     <= in_v;
      mul_v_r <= in_v;
    end
  end

  assign out_v   = v_r;
  assign out_k   = k_r;
  assign out_a   = a_r;
  assign res_out = res_r;

endmodule
`default_nettype wire

FILE: design/matrix_multiply.sv
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_multiply
// Dense matrix product C = A x B on signed Q8.8 elements, with a chain of
// column cells that accumulate one row of C at a time.
// ---------------------------------------------------------------------------
// Load words are taken one per cycle while the block is idle and cause no
// result. A start word steps, for each row of C, through S_ROW, S_ISSUE (the
// A reads from the single RAM port), S_FLUSH (the wave through the cell
// chain), S_LOAD and S_DRAIN: one result drained per cycle through the
// output unless it stalls. Reset clears control state and sets all three
// dimensions to 8; the element stores are not cleared.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::DEF_MAX_DIM
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mm_pkg::in_word_t           in_word,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mm_pkg::out_word_t               out_word,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mm_pkg::APB_DW-1:0]  pwdata,
  output logic      [mm_pkg::APB_DW-1:0]  prdata,
  output logic                            pready
);
  import mm_pkg::*;

  localparam int DW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW      = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FLUSH_N = MAX_DIM + 3;
  localparam int FW      = $clog2(FLUSH_N + 1);

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  state_t           state_r, state_nxt;
  logic [DW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [FW-1:0]    f_r, f_nxt;
  logic [CW-1:0]    n_r, n_nxt, m_r, m_nxt, p_r, p_nxt;
  logic [CW-1:0]    n_s, m_s, p_s;
  logic             out_valid_r;
  out_word_t        out_data_r;
  logic             rd_v_r;
  logic [DW-1:0]    rd_k_r;

  logic             in_fire, cfg_wr, load_ok, clr, ld, sh, rd_en, push, out_free;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] rd_data;

  logic                    cv   [MAX_DIM+1];
  logic [DW-1:0]           ck   [MAX_DIM+1];
  logic signed [VAL_W-1:0] ca   [MAX_DIM+1];
  logic signed [SUM_W-1:0] cres [MAX_DIM+1];

  function automatic logic [CW-1:0] limit_dim(input logic [DIM_W-1:0] d);
    logic [CW-1:0] r;
    if (int'(d) > MAX_DIM) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(d);
    end
    return r;
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = (int'(in_word.row) < MAX_DIM) && (int'(in_word.col) < MAX_DIM);
  assign wr_addr  = AW'(int'(in_word.row) * MAX_DIM + int'(in_word.col));
  assign rd_addr  = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign out_free = !out_valid_r || out_ready;
  assign n_s      = limit_dim(rows_a_r);
  assign m_s      = limit_dim(inner_dim_r);
  assign p_s      = limit_dim(cols_b_r);

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = APB_DW'(rows_a_r);
      REG_INNER_DIM: prdata = APB_DW'(inner_dim_r);
      REG_COLS_B:    prdata = APB_DW'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a_r    <= pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  mm_ram #(.W(VAL_W), .D(DEPTH)) u_a_ram (
    .clk     (clk),
    .wr_en   (in_fire && load_ok && (in_word.cmd == CMD_LOAD_A)),
    .wr_addr (wr_addr),
    .wr_data (in_word.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cv[0] = rd_v_r;
  assign ck[0] = rd_k_r;
  assign ca[0] = $signed(rd_data);
  assign cres[MAX_DIM] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mm_cell #(.MAX_DIM(MAX_DIM)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .b_we    (in_fire && load_ok && (in_word.cmd == CMD_LOAD_B) &&
                (int'(in_word.col) == c)),
      .b_row   (DW'(in_word.row)),
      .b_data  (in_word.value),
      .clr     (clr),
      .in_v    (cv[c]),
      .in_k    (ck[c]),
      .in_a    (ca[c]),
      .out_v   (cv[c+1]),
      .out_k   (ck[c+1]),
      .out_a   (ca[c+1]),
      .ld      (ld),
      .sh      (sh),
      .res_in  (cres[c+1]),
      .res_out (cres[c])
    );
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    f_nxt     = f_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    p_nxt     = p_r;
    clr       = 1'b0;
    ld        = 1'b0;
    sh        = 1'b0;
    rd_en     = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_word.cmd == CMD_START)) begin
          n_nxt = n_s;
          m_nxt = m_s;
          p_nxt = p_s;
          i_nxt = '0;
          if ((n_s != '0) && (p_s != '0)) begin
            state_nxt = S_ROW;
          end
        end
      end
      S_ROW: begin
        clr   = 1'b1;
        k_nxt = '0;
        j_nxt = '0;
        f_nxt = '0;
        state_nxt = (m_r != '0) ? S_ISSUE : S_FLUSH;
      end
      S_ISSUE: begin
        rd_en = 1'b1;
        k_nxt = k_r + DW'(1);
        if (CW'(k_r) == m_r - CW'(1)) begin
          f_nxt     = '0;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        f_nxt = f_r + FW'(1);
        if (f_r == FW'(FLUSH_N - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        ld        = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (out_free) begin
          push  = 1'b1;
          sh    = 1'b1;
          j_nxt = j_r + DW'(1);
          if (CW'(j_r) == p_r - CW'(1)) begin
            if (CW'(i_r) == n_r - CW'(1)) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + DW'(1);
              state_nxt = S_ROW;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_en;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    f_r    <= f_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    p_r    <= p_nxt;
    rd_k_r <= k_r;
    if (push) begin
      out_data_r.out_row <= ROW_W'(i_r);
      out_data_r.out_col <= COL_W'(j_r);
      out_data_r.sum     <= cres[0];
      out_data_r.last    <= (CW'(j_r) == p_r - CW'(1)) && (CW'(i_r) == n_r - CW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_data_r;

  a_no_wave_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !rd_v_r)
    else $error("A element still in flight when sums are captured.");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (CW'(k_r) < m_r))
    else $error("Inner index ran past the inner dimension.");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (CW'(j_r) == p_r - CW'(1)) && (CW'(i_r) == n_r - CW'(1)))
      |=> (state_r == S_IDLE))
    else $error("Final word pushed but the block did not return to idle.");

endmodule
`default_nettype wire

FILE: bench/matrix_multiply_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_multiply_test
// Self-checking bench for the matrix multiply block. A directed table covers
// value extremes, every command, zero and oversized dimensions; random
// phases then set dimensions, load random elements and start products.
// Every result word is checked against a local model of the product.
// ---------------------------------------------------------------------------
module matrix_multiply_test;
  import mm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DIM      = 8;
  localparam int SETTLE   = 60;
  localparam int HOLD_LEN = 400;
  localparam int LIMIT    = 600000;

  typedef struct {
    logic [3:0]         ra;
    logic [3:0]         id;
    logic [3:0]         cb;
    in_word_t           w;
    bit                 typed;
    logic signed [47:0] sum;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic signed [15:0] a_elem [DIM*DIM];
  logic signed [15:0] b_elem [DIM*DIM];
  bit a_known [DIM*DIM];
  bit b_known [DIM*DIM];
  logic [3:0] rows_cfg = 4'd8;
  logic [3:0] inner_cfg = 4'd8;
  logic [3:0] cols_cfg = 4'd8;
  out_word_t product_q [$];
  int errors = 0;
  int cycles = 0;
  int words_seen = 0;
  int words_sent = 0;
  bit fast_in = 1'b0;
  step_t plan [21];

  matrix_multiply u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  function automatic int clamp_dim(logic [3:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  // Applies an accepted word to the stores; queues products or the typed sum.
  function automatic void model_word(in_word_t w, bit typed, logic signed [47:0] sum);
    int n, m, p, addr;
    logic signed [47:0] acc;
    out_word_t r;
    n = clamp_dim(rows_cfg);
    m = clamp_dim(inner_cfg);
    p = clamp_dim(cols_cfg);
    addr = int'(w.row) * DIM + int'(w.col);
    if (w.cmd == CMD_LOAD_A) begin
      a_elem[addr] = w.value;
      a_known[addr] = 1'b1;
    end else if (w.cmd == CMD_LOAD_B) begin
      b_elem[addr] = w.value;
      b_known[addr] = 1'b1;
    end else if (w.cmd == CMD_START && typed) begin
      r.out_row = '0;
      r.out_col = '0;
      r.sum = sum;
      r.last = 1'b1;
      product_q.push_back(r);
    end else if (w.cmd == CMD_START) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = '0;
          for (int k = 0; k < m; k++)
            acc += 48'(a_elem[i*DIM+k]) * 48'(b_elem[k*DIM+j]);
          r.out_row = i[2:0];
          r.out_col = j[2:0];
          r.sum = acc;
          r.last = (i == n - 1) && (j == p - 1);
          product_q.push_back(r);
        end
      end
    end
  endfunction

  task automatic send_word(in_word_t w, bit typed, logic signed [47:0] sum);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    model_word(w, typed, sum);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_access(logic [1:0] idx, bit wr, logic [31:0] data,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(logic [3:0] ra, logic [3:0] id, logic [3:0] cb);
    logic [31:0] rd;
    cfg_access(REG_ROWS_A, 1'b1, {28'd0, ra}, rd);
    cfg_access(REG_INNER_DIM, 1'b1, {28'd0, id}, rd);
    cfg_access(REG_COLS_B, 1'b1, {28'd0, cb}, rd);
    rows_cfg = ra;
    inner_cfg = id;
    cols_cfg = cb;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_phase();
    in_word_t q [$];
    in_word_t w, t;
    logic [3:0] ra, id, cb;
    int n, m, p, s;
    ra = pick_dim();
    id = pick_dim();
    cb = pick_dim();
    wait_idle();
    set_dims(ra, id, cb);
    fast_in = ($urandom_range(0, 3) == 0);
    n = clamp_dim(ra);
    m = clamp_dim(id);
    p = clamp_dim(cb);
    // Only starts whose operands are all loaded are issued.
    if (n > 0 && p > 0) begin
      for (int i = 0; i < n; i++)
        for (int k = 0; k < m; k++)
          if (!a_known[i*DIM+k]) q.push_back({CMD_LOAD_A, 3'(i), 3'(k), pick_value()});
      for (int k = 0; k < m; k++)
        for (int j = 0; j < p; j++)
          if (!b_known[k*DIM+j]) q.push_back({CMD_LOAD_B, 3'(k), 3'(j), pick_value()});
    end
    repeat ($urandom_range(1, 5)) begin
      w.cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
      w.row = 3'($urandom);
      w.col = 3'($urandom);
      w.value = pick_value();
      q.push_back(w);
    end
    if ($urandom_range(0, 3) == 0) q.push_back({CMD_UNUSED, 22'($urandom)});
    for (int i = q.size() - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      t = q[i];
      q[i] = q[s];
      q[s] = t;
    end
    foreach (q[i]) send_word(q[i], 1'b0, '0);
    repeat ($urandom_range(1, 2)) send_word({CMD_START, 22'($urandom)}, 1'b0, '0);
  endtask

  // Result side: random stalls per word in alternate runs of 50 words, plus one
  // long hold-off taken while the sender is blocked with a word on offer.
  initial begin
    int stall;
    bit held;
    out_word_t want;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && words_seen >= 20 && in_valid && !in_ready) begin
        held = 1'b1;
        stall = HOLD_LEN;
      end else if ((words_seen / 50) % 2 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_seen++;
      if (product_q.size() == 0) begin
        report("unexpected word", out_word.sum, 0);
      end else begin
        want = product_q.pop_front();
        if (out_word.out_row !== want.out_row) report("out_row", out_word.out_row, want.out_row);
        if (out_word.out_col !== want.out_col) report("out_col", out_word.out_col, want.out_col);
        if (out_word.sum !== want.sum) report("sum", out_word.sum, want.sum);
        if (out_word.last !== want.last) report("last", out_word.last, want.last);
      end
    end
  end

  initial begin
    logic [31:0] rd;
    plan = '{
      '{4'd1, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd0, 3'd0, -16'sd32768}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_LOAD_B, 3'd0, 3'd0, -16'sd32768}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b1, 48'sd1073741824},
      '{4'd1, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd0, 3'd0, 16'sd32767}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b1, -48'sd1073709056},
      '{4'd1, 4'd1, 4'd1, '{CMD_LOAD_B, 3'd0, 3'd0, 16'sd0}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b1, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_UNUSED, 3'd7, 3'd7, 16'sh5a5a}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_LOAD_B, 3'd0, 3'd0, 16'sd256}, 1'b0, 48'sd0},
      '{4'd0, 4'd1, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b0, 48'sd0},
      '{4'd1, 4'd0, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b1, 48'sd0},
      '{4'd1, 4'd1, 4'd0, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd1, 3'd0, 16'sd256}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd2, 3'd0, -16'sd256}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd3, 3'd0, 16'sd32767}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd4, 3'd0, -16'sd32768}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd5, 3'd0, 16'sd1}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd6, 3'd0, -16'sd1}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_LOAD_A, 3'd7, 3'd0, 16'sh1234}, 1'b0, 48'sd0},
      '{4'd15, 4'd1, 4'd1, '{CMD_START, 3'd7, 3'd7, -16'sd1}, 1'b0, 48'sd0},
      '{4'd1, 4'd1, 4'd1, '{CMD_START, 3'd0, 3'd0, 16'sd0}, 1'b1, 48'sd8388352}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(REG_ROWS_A, 1'b0, '0, rd);
    if (rd[3:0] !== DIM_RESET) report("rows_a after reset", rd, DIM_RESET);
    cfg_access(REG_INNER_DIM, 1'b0, '0, rd);
    if (rd[3:0] !== DIM_RESET) report("inner_dim after reset", rd, DIM_RESET);
    cfg_access(REG_COLS_B, 1'b0, '0, rd);
    if (rd[3:0] !== DIM_RESET) report("cols_b after reset", rd, DIM_RESET);
    foreach (plan[i]) begin
      if (plan[i].ra != rows_cfg || plan[i].id != inner_cfg || plan[i].cb != cols_cfg) begin
        wait_idle();
        set_dims(plan[i].ra, plan[i].id, plan[i].cb);
      end
      send_word(plan[i].w, plan[i].typed, plan[i].sum);
    end
    words_sent = 0;
    while (words_sent < 100) random_phase();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
